// File: rtl/bctg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the bicubic tap coordinate generator.
// Used by the channel interfaces, the controller, the datapath and the top level.

package bctg_pkg;

  localparam int OFFSET_W   = 25;
  localparam int T_W        = 16;
  localparam int STEP_W     = 32;
  localparam int STRIDE_W   = 14;
  localparam int COUNT_W    = 14;
  localparam int CNT_W      = 13;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int TAPS       = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_STEP   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INDEX    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 8'd3;

  localparam logic [COUNT_W-1:0]  MAX_COUNT          = 14'd8192;
  localparam logic [COUNT_W-1:0]  OUTPUT_COUNT_RESET = 14'd4096;
  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RESET   = 14'd1;
  localparam logic [31:0]         MAX_INDEX_RESET    = 32'd4095;

  typedef struct packed {
    logic load_in;
    logic calc;
    logic mul_a;
    logic load_out;
  } bctg_cmd_t;

endpackage

// File: rtl/bctg_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input item, result item and register writes.
// Depends on bctg_pkg for the field widths.

interface bctg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface bctg_out_if;
  logic                          valid;
  logic                          ready;
  logic [bctg_pkg::OFFSET_W-1:0] offset_minus1;
  logic [bctg_pkg::OFFSET_W-1:0] offset_zero;
  logic [bctg_pkg::OFFSET_W-1:0] offset_plus1;
  logic [bctg_pkg::OFFSET_W-1:0] offset_plus2;
  logic [bctg_pkg::T_W-1:0]      frac_t;
  logic [bctg_pkg::T_W-1:0]      frac_t_squared;
  logic [bctg_pkg::T_W-1:0]      frac_t_cubed;
  logic                          last;

  modport source (output valid, output offset_minus1, output offset_zero,
                  output offset_plus1, output offset_plus2, output frac_t,
                  output frac_t_squared, output frac_t_cubed, output last,
                  input ready);
  modport sink (input valid, input offset_minus1, input offset_zero,
                input offset_plus1, input offset_plus2, input frac_t,
                input frac_t_squared, input frac_t_cubed, input last,
                output ready);
endinterface

interface bctg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bctg_pkg::CFG_IDX_W-1:0]  index;
  logic [bctg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/bicubic_tap_coordinate_generator_top.sv
`timescale 1ns / 1ps
// Top level of the bicubic tap coordinate generator.
// Depends on bctg_pkg, the channel interfaces, bctg_ctrl and bctg_datapath.

// Each accepted item yields one result: the four clamped, stride-scaled
// neighbour offsets around the current source position, the fraction t with
// t squared and t cubed, and a flag on the last position of the line. An
// item passes from acceptance to the result register through the
// accept/accumulate step, the floor and clamp step and the two chained
// multiplies of the fraction; the last step waits while the result register
// holds an untaken item. The next item is accepted only once the previous
// one has reached the result register. Register writes are taken
// in every cycle and should only be made while the block is idle.

module bicubic_tap_coordinate_generator_top #(
  parameter int FRAC_BITS  = 16,
  parameter int INDEX_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  bctg_in_if.sink     in_ch,
  bctg_out_if.source  out_ch,
  bctg_cfg_if.sink    cfg_ch
);

  bctg_pkg::bctg_cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  bctg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  bctg_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .restart        (in_ch.restart),
    .cfg_we         (cfg_ch.valid && cfg_ch.ready),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .offset_minus1  (out_ch.offset_minus1),
    .offset_zero    (out_ch.offset_zero),
    .offset_plus1   (out_ch.offset_plus1),
    .offset_plus2   (out_ch.offset_plus2),
    .frac_t         (out_ch.frac_t),
    .frac_t_squared (out_ch.frac_t_squared),
    .frac_t_cubed   (out_ch.frac_t_cubed),
    .last           (out_ch.last)
  );

endmodule

// File: rtl/bctg_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine and output valid flag of the coordinate generator.
// Depends on bctg_pkg for the command struct.

module bctg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bctg_pkg::bctg_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_MUL1 = 4'b0100,
    S_MUL2 = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("State register is not one-hot.");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_CALC)
    else $error("Accepted item did not start the calculation.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("Result register loaded over an untaken item.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid && state_r == S_IDLE)
    else $error("Loaded result not presented.");
`endif

endmodule

// File: rtl/bctg_datapath.sv
`timescale 1ns / 1ps
// Configuration registers, position accumulator, tap clamping and multipliers.
// Depends on bctg_pkg; driven by commands from bctg_ctrl.

module bctg_datapath #(
  parameter int FRAC_BITS  = 16,
  parameter int INDEX_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bctg_pkg::bctg_cmd_t               cmd,
  input  logic                              restart,
  input  logic                              cfg_we,
  input  logic [bctg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bctg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [bctg_pkg::OFFSET_W-1:0]     offset_minus1,
  output logic [bctg_pkg::OFFSET_W-1:0]     offset_zero,
  output logic [bctg_pkg::OFFSET_W-1:0]     offset_plus1,
  output logic [bctg_pkg::OFFSET_W-1:0]     offset_plus2,
  output logic [bctg_pkg::T_W-1:0]          frac_t,
  output logic [bctg_pkg::T_W-1:0]          frac_t_squared,
  output logic [bctg_pkg::T_W-1:0]          frac_t_cubed,
  output logic                              last
);

  localparam int STEP_W   = bctg_pkg::STEP_W;
  localparam int T_W      = bctg_pkg::T_W;
  localparam int OFFSET_W = bctg_pkg::OFFSET_W;
  localparam int CNT_W    = bctg_pkg::CNT_W;
  localparam int IDX_W    = STEP_W + 2;
  localparam int TAPS     = bctg_pkg::TAPS;
  localparam logic [STEP_W-1:0] HALF        = STEP_W'(1) << (FRAC_BITS - 1);
  localparam logic [STEP_W-1:0] SCALE_RESET = STEP_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] ACC_RESET   = (SCALE_RESET >> 1) - HALF;

  logic [STEP_W-1:0]             scale_step_r;
  logic [INDEX_BITS-1:0]         max_index_r;
  logic [bctg_pkg::STRIDE_W-1:0] row_stride_r;
  logic [bctg_pkg::COUNT_W-1:0]  output_count_r;

  logic [STEP_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [STEP_W-1:0] start_pos, acc_sel;
  logic [CNT_W-1:0]  cnt_sel, cnt_last;
  logic [bctg_pkg::COUNT_W-1:0] count_eff;
  logic              is_last;

  logic [STEP_W-1:0] pos_r;
  logic              last_r;
  logic              last_q_r;

  logic signed [IDX_W-1:0] base;
  logic signed [IDX_W-1:0] hi;
  logic signed [IDX_W-1:0] tap_idx [TAPS];
  logic [INDEX_BITS-1:0]   clamp_nxt [TAPS];
  logic [INDEX_BITS-1:0]   clamp_r [TAPS];
  logic [FRAC_BITS+T_W-1:0] frac_ext;
  logic [T_W-1:0]          t_nxt, t_r, t_q_r;

  logic [OFFSET_W-1:0]     off_r [TAPS];
  logic [2*T_W-1:0]        prod_tt, prod_ttt;
  logic [T_W-1:0]          t2_r;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_step_r   <= SCALE_RESET;
      max_index_r    <= INDEX_BITS'(bctg_pkg::MAX_INDEX_RESET);
      row_stride_r   <= bctg_pkg::ROW_STRIDE_RESET;
      output_count_r <= bctg_pkg::OUTPUT_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bctg_pkg::REG_SCALE_STEP:   scale_step_r   <= cfg_data;
        bctg_pkg::REG_MAX_INDEX:    max_index_r    <= INDEX_BITS'(cfg_data);
        bctg_pkg::REG_ROW_STRIDE:   row_stride_r   <= bctg_pkg::STRIDE_W'(cfg_data);
        bctg_pkg::REG_OUTPUT_COUNT: output_count_r <= bctg_pkg::COUNT_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Position of the item being accepted and the position that follows it.
  always_comb begin
    start_pos = (scale_step_r >> 1) - HALF;
    acc_sel   = restart ? start_pos : acc_r;
    cnt_sel   = restart ? '0 : cnt_r;
    if (output_count_r == '0 || output_count_r > bctg_pkg::MAX_COUNT) begin
      count_eff = bctg_pkg::MAX_COUNT;
    end else begin
      count_eff = output_count_r;
    end
    cnt_last = CNT_W'(count_eff - bctg_pkg::COUNT_W'(1));
    is_last  = (cnt_sel == cnt_last);
    acc_nxt  = is_last ? start_pos : acc_sel + scale_step_r;
    cnt_nxt  = is_last ? '0 : cnt_sel + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= ACC_RESET;
      cnt_r <= '0;
    end else if (cmd.load_in) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pos_r  <= acc_sel;
      last_r <= is_last;
    end
  end

  // Floor, clamped neighbour indices and the fraction in Q0.16.
  always_comb begin
    base     = IDX_W'($signed(pos_r) >>> FRAC_BITS);
    hi       = $signed(IDX_W'(max_index_r));
    frac_ext = {pos_r[FRAC_BITS-1:0], {T_W{1'b0}}};
    t_nxt    = T_W'(frac_ext >> FRAC_BITS);
    for (int k = 0; k < TAPS; k++) begin
      tap_idx[k] = base + IDX_W'(k) - IDX_W'(1);
      if (tap_idx[k] < 0) begin
        clamp_nxt[k] = '0;
      end else if (tap_idx[k] > hi) begin
        clamp_nxt[k] = max_index_r;
      end else begin
        clamp_nxt[k] = INDEX_BITS'(tap_idx[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      clamp_r  <= clamp_nxt;
      t_r      <= t_nxt;
      last_q_r <= last_r;
    end
  end

  // Stride products and the square of the fraction.
  assign prod_tt = t_r * t_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      for (int k = 0; k < TAPS; k++) begin
        off_r[k] <= OFFSET_W'(clamp_r[k] * row_stride_r);
      end
      t2_r  <= prod_tt[2*T_W-1:T_W];
      t_q_r <= t_r;
    end
  end

  // Cube of the fraction goes straight into the result register.
  assign prod_ttt = t2_r * t_q_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      offset_minus1  <= off_r[0];
      offset_zero    <= off_r[1];
      offset_plus1   <= off_r[2];
      offset_plus2   <= off_r[3];
      frac_t         <= t_q_r;
      frac_t_squared <= t2_r;
      frac_t_cubed   <= prod_ttt[2*T_W-1:T_W];
      last           <= last_q_r;
    end
  end

endmodule
